// ===== rtl/isort_pkg.sv =====
// shared types and constants of the insertion sorter
package isort_pkg;

    // default store depth
    localparam int MAX_ITEMS_DEF = 32;
    localparam int KEY_W         = 32;

    // input word
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    final_key;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic                    run_end;
        logic                    overflow;
    } t_out_word;

    // control broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    shift;
        logic signed [KEY_W-1:0] key;
    } t_cell_ctl;

    // sequencer states
    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/isort_cell.sv =====
// one compare-and-shift cell of the sorted chain
module isort_cell
    import isort_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic                    i_occ,
    input  logic                    i_slot,
    input  logic signed [KEY_W-1:0] i_left_key,
    input  logic                    i_left_gt,
    input  logic signed [KEY_W-1:0] i_right_key,
    output logic signed [KEY_W-1:0] o_key,
    output logic                    o_gt
);

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;

    // held key is strictly greater than the arriving key
    assign o_gt  = i_occ && ($signed(r_key) > $signed(i_ctl.key));
    assign o_key = r_key;

    // insert: move right when displaced, take new key at the boundary
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && (o_gt || i_slot)) begin
            n_key = i_left_gt ? i_left_key : i_ctl.key;
        end else if (i_ctl.shift) begin
            n_key = i_right_key;
        end
    end

    // key register
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ===== rtl/insertion_sorter_top.sv =====
// Insertion sorter: top level with the cell chain and its sequencer.
// Keys are taken one per clock while busy is low (start high accepts a word);
// each key is placed into a chain of MAX_ITEMS cells, after every held key
// that is less than or equal to it. A word with final_key set is inserted and
// then the held run of n keys (1..MAX_ITEMS) is shifted out of cell 0, one
// key per cycle, with busy high while the run is shifted out; results are
// registered and appear on o_word in the cycle after each shift, marked by
// o_strobe, the last with run_end. Overflow is set on the whole run if keys
// were dropped because the chain was full. The receiver cannot stall, and no
// result is ever held back. The next set may start in the cycle busy falls.
module insertion_sorter_top
    import isort_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_word
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_state    r_state;
    t_state    n_state;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic      r_drop;
    logic      n_drop;
    logic      r_out_valid;
    t_out_word r_out;

    logic      w_accept;
    logic      w_full;
    logic      w_busy;
    t_cell_ctl w_ctl;

    logic signed [KEY_W-1:0] w_key [MAX_ITEMS];
    logic                    w_gt  [MAX_ITEMS];
    logic                    w_occ [MAX_ITEMS];

    assign w_full   = (r_fill == CW'(MAX_ITEMS));
    assign w_accept = start && !w_busy;

    // cell chain
    for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
        logic                    w_slot;
        logic signed [KEY_W-1:0] w_lkey;
        logic                    w_lgt;
        logic signed [KEY_W-1:0] w_rkey;

        assign w_occ[gi] = (CW'(gi) < r_fill);

        if (gi == 0) begin : g_head
            assign w_slot = !w_occ[gi];
            assign w_lkey = '0;
            assign w_lgt  = 1'b0;
        end else begin : g_body
            assign w_slot = !w_occ[gi] && w_occ[gi-1];
            assign w_lkey = w_key[gi-1];
            assign w_lgt  = w_gt[gi-1];
        end

        if (gi == MAX_ITEMS - 1) begin : g_tail
            assign w_rkey = w_key[gi];
        end else begin : g_mid
            assign w_rkey = w_key[gi+1];
        end

        isort_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[gi]),
            .i_slot      (w_slot),
            .i_left_key  (w_lkey),
            .i_left_gt   (w_lgt),
            .i_right_key (w_rkey),
            .o_key       (w_key[gi]),
            .o_gt        (w_gt[gi])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && i_word.final_key) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_fill == CW'(1)) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_busy      = 1'b0;
        w_ctl.ins   = 1'b0;
        w_ctl.shift = 1'b0;
        w_ctl.key   = i_word.key;
        case (r_state)
            ST_LOAD: begin
                w_ctl.ins = w_accept && !w_full;
            end
            ST_EMIT: begin
                w_busy      = 1'b1;
                w_ctl.shift = 1'b1;
            end
            default: begin
                w_busy = 1'b0;
            end
        endcase
    end

    // fill count and drop flag
    always_comb begin
        n_fill = r_fill;
        n_drop = r_drop;
        if (w_ctl.ins) begin
            n_fill = r_fill + CW'(1);
        end
        if (r_state == ST_LOAD && w_accept && w_full) begin
            n_drop = 1'b1;
        end
        if (w_ctl.shift) begin
            n_fill = r_fill - CW'(1);
            if (r_fill == CW'(1)) n_drop = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_out_valid <= w_ctl.shift;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_ctl.shift) begin
            r_out.sorted_key <= w_key[0];
            r_out.run_end    <= (r_fill == CW'(1));
            r_out.overflow   <= r_drop;
        end
    end

    assign busy     = w_busy;
    assign o_strobe = r_out_valid;
    assign o_word   = r_out;

    // a result word only follows a shift cycle
    a_strobe_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == ST_EMIT))
        else $error("result strobe without emission");

    // fill count never passes the chain length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_ITEMS))
        else $error("fill count beyond chain length");

    // a final word starts emission
    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && w_accept && i_word.final_key) |=> r_state == ST_EMIT)
        else $error("final word did not start emission");

    // the end of a run leaves the block empty and loading
    a_run_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.run_end) |-> (r_state == ST_LOAD && r_fill == '0 && !r_drop))
        else $error("run end left state behind");

    // emission never runs with an empty chain
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_fill != '0))
        else $error("emission with empty chain");

endmodule
